// ===== sv/assert_macros.svh =====
// Assertion macros used by the datapath RTL file of the articulation point finder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define AP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define AP_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define AP_ASSERT(lbl, clk, rstn, prop, msg)
`define AP_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== sv/apf_pkg.sv =====
// Package with shared types and constants of the articulation point finder.
`default_nettype none
package apf_pkg;

  localparam int DefMaxVertices = 64;
  localparam int DefMaxEdges    = 256;
  localparam int FieldW         = 7;
  localparam logic [FieldW-1:0] VcReset = 7'd64;

  localparam logic CmdAdd = 1'b0;
  localparam logic CmdRun = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADD_WRA, ST_ADD_RDB, ST_ADD_WRB, ST_SCAN, ST_PUSH_FE, ST_STEP,
    ST_EDGE, ST_VIS, ST_POP, ST_COUNT, ST_EMIT, ST_CLEAR
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_DROP, OP_LOAD, OP_RUN, OP_WR_A, OP_RD_B, OP_WR_B, OP_SCAN_SKIP,
    OP_ROOT, OP_SET_CUR, OP_RD_EDGE, OP_SKIP_EDGE, OP_TEST, OP_CHILD, OP_BACK,
    OP_POP, OP_POP_DONE, OP_MERGE, OP_COUNT_START, OP_COUNT, OP_EMIT_START,
    OP_EMIT, OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t op;
  } apf_cmd_t;

  typedef struct packed {
    logic in_take;
    logic in_run;
    logic add_ok;
    logic scan_done;
    logic root_visited;
    logic cursor_zero;
    logic deep;
    logic edge_skip;
    logic tgt_unvisited;
    logic can_push;
    logic count_done;
    logic emit_fin;
  } apf_stat_t;

endpackage
`default_nettype wire

// ===== sv/articulation_point_finder.sv =====
// Top level of the articulation point finder: controller plus datapath.
`default_nettype none
// An add transaction (cmd 0) stores one undirected edge, or is dropped when
// an endpoint is out of range or the store is full.
// A run transaction (cmd 1) walks the graph depth first with an explicit
// stack: it scans the vertices for unvisited roots, reads each adjacency entry
// and skips it or tests its target, and pushes and pops vertices, each step set
// by the registered reads of the edge, visit and stack memories. It then counts
// cut marks vertex by vertex, steps through the vertices again one per cycle to
// emit one result per cut vertex (or one result with found 0) in ascending
// order, waiting on out_stall, and clears all stores.
// No clearing pass is needed after reset.
module articulation_point_finder #(
  parameter int MAX_VERTICES = apf_pkg::DefMaxVertices,
  parameter int MAX_EDGES    = apf_pkg::DefMaxEdges
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [apf_pkg::FieldW-1:0]  cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_cmd,
  input  wire logic [apf_pkg::FieldW-1:0]  in_end_a,
  input  wire logic [apf_pkg::FieldW-1:0]  in_end_b,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [apf_pkg::FieldW-1:0]       out_cut_vertex,
  output logic                             out_found,
  output logic [apf_pkg::FieldW-1:0]       out_cut_count,
  output logic                             out_overflow,
  output logic                             out_last
);

  apf_pkg::apf_cmd_t  cmd;
  apf_pkg::apf_stat_t stat;
  logic               busy;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  apf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  apf_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .busy           (busy),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_cmd         (in_cmd),
    .in_end_a       (in_end_a),
    .in_end_b       (in_end_b),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cut_vertex (out_cut_vertex),
    .out_found      (out_found),
    .out_cut_count  (out_cut_count),
    .out_overflow   (out_overflow),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

// ===== sv/apf_ctrl.sv =====
// Controller state machine that sequences edge loads, the walk and the output.
`default_nettype none
module apf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire apf_pkg::apf_stat_t stat,
  output apf_pkg::apf_cmd_t       cmd,
  output logic                    busy
);

  apf_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command.
  always_comb begin
    state_nxt = state_r;
    cmd.op    = apf_pkg::OP_NONE;
    busy      = (state_r != apf_pkg::ST_IDLE);
    case (state_r)
      apf_pkg::ST_IDLE: begin
        if (stat.in_take) begin
          if (stat.in_run) begin
            cmd.op    = apf_pkg::OP_RUN;
            state_nxt = apf_pkg::ST_SCAN;
          end else if (stat.add_ok) begin
            cmd.op    = apf_pkg::OP_LOAD;
            state_nxt = apf_pkg::ST_ADD_WRA;
          end else begin
            cmd.op = apf_pkg::OP_DROP;
          end
        end
      end
      apf_pkg::ST_ADD_WRA: begin
        cmd.op    = apf_pkg::OP_WR_A;
        state_nxt = apf_pkg::ST_ADD_RDB;
      end
      apf_pkg::ST_ADD_RDB: begin
        cmd.op    = apf_pkg::OP_RD_B;
        state_nxt = apf_pkg::ST_ADD_WRB;
      end
      apf_pkg::ST_ADD_WRB: begin
        cmd.op    = apf_pkg::OP_WR_B;
        state_nxt = apf_pkg::ST_IDLE;
      end
      apf_pkg::ST_SCAN: begin
        if (stat.scan_done) begin
          cmd.op    = apf_pkg::OP_COUNT_START;
          state_nxt = apf_pkg::ST_COUNT;
        end else if (stat.root_visited) begin
          cmd.op = apf_pkg::OP_SCAN_SKIP;
        end else begin
          cmd.op    = apf_pkg::OP_ROOT;
          state_nxt = apf_pkg::ST_PUSH_FE;
        end
      end
      apf_pkg::ST_PUSH_FE: begin
        cmd.op    = apf_pkg::OP_SET_CUR;
        state_nxt = apf_pkg::ST_STEP;
      end
      apf_pkg::ST_STEP: begin
        if (!stat.cursor_zero) begin
          cmd.op    = apf_pkg::OP_RD_EDGE;
          state_nxt = apf_pkg::ST_EDGE;
        end else if (stat.deep) begin
          cmd.op    = apf_pkg::OP_POP;
          state_nxt = apf_pkg::ST_POP;
        end else begin
          cmd.op    = apf_pkg::OP_POP_DONE;
          state_nxt = apf_pkg::ST_SCAN;
        end
      end
      apf_pkg::ST_EDGE: begin
        if (stat.edge_skip) begin
          cmd.op    = apf_pkg::OP_SKIP_EDGE;
          state_nxt = apf_pkg::ST_STEP;
        end else begin
          cmd.op    = apf_pkg::OP_TEST;
          state_nxt = apf_pkg::ST_VIS;
        end
      end
      apf_pkg::ST_VIS: begin
        if (stat.tgt_unvisited) begin
          cmd.op    = apf_pkg::OP_CHILD;
          state_nxt = stat.can_push ? apf_pkg::ST_PUSH_FE : apf_pkg::ST_STEP;
        end else begin
          cmd.op    = apf_pkg::OP_BACK;
          state_nxt = apf_pkg::ST_STEP;
        end
      end
      apf_pkg::ST_POP: begin
        cmd.op    = apf_pkg::OP_MERGE;
        state_nxt = apf_pkg::ST_STEP;
      end
      apf_pkg::ST_COUNT: begin
        if (stat.count_done) begin
          cmd.op    = apf_pkg::OP_EMIT_START;
          state_nxt = apf_pkg::ST_EMIT;
        end else begin
          cmd.op = apf_pkg::OP_COUNT;
        end
      end
      apf_pkg::ST_EMIT: begin
        cmd.op = apf_pkg::OP_EMIT;
        if (stat.emit_fin) begin
          state_nxt = apf_pkg::ST_CLEAR;
        end
      end
      apf_pkg::ST_CLEAR: begin
        cmd.op    = apf_pkg::OP_CLEAR;
        state_nxt = apf_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = apf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/apf_dp.sv =====
// Datapath: adjacency store, visit store, walk stack, cut marks and output register.
`default_nettype none
`include "assert_macros.svh"
module apf_dp #(
  parameter int MAX_VERTICES = apf_pkg::DefMaxVertices,
  parameter int MAX_EDGES    = apf_pkg::DefMaxEdges
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire apf_pkg::apf_cmd_t           cmd,
  output apf_pkg::apf_stat_t               stat,
  input  wire logic                        busy,
  input  wire logic                        cfg_valid,
  input  wire logic [apf_pkg::FieldW-1:0]  cfg_data,
  input  wire logic                        in_valid,
  input  wire logic                        in_cmd,
  input  wire logic [apf_pkg::FieldW-1:0]  in_end_a,
  input  wire logic [apf_pkg::FieldW-1:0]  in_end_b,
  output logic                             in_stall,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [apf_pkg::FieldW-1:0]       out_cut_vertex,
  output logic                             out_found,
  output logic [apf_pkg::FieldW-1:0]       out_cut_count,
  output logic                             out_overflow,
  output logic                             out_last
);

  localparam int FW = apf_pkg::FieldW;
  localparam int VW = $clog2(MAX_VERTICES + 1);
  localparam int SW = $clog2(2 * MAX_EDGES + 1);
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int KW = $clog2(MAX_VERTICES);

  // Configuration register.
  logic [FW-1:0] vc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= apf_pkg::VcReset;
    end else if (cfg_valid) begin
      vc_r <= cfg_data;
    end
  end

  // Vertex count clamped to the store size.
  logic [FW-1:0] n7;
  logic [VW-1:0] n_v;
  assign n7  = (MAX_VERTICES < 128 && vc_r > FW'(MAX_VERTICES)) ? FW'(MAX_VERTICES) : vc_r;
  assign n_v = VW'(n7);

  // Control registers.
  logic [VW-1:0] a_r, b_r;
  logic [EW-1:0] et_r;
  logic          drop_r, ovf_r;
  logic [VW:0]   r_r, i_r;
  logic [VW-1:0] cnt_r, cc_r, em_r, d_r;
  logic [MAX_VERTICES:0] vo_vld_r, fe_vld_r, cut_r;

  // Top of stack held in registers.
  logic [VW-1:0] tv_r, tp_r, tch_r, tl_r, to_r;
  logic [SW-1:0] tc_r;
  logic          tf_r;

  // Registered memory read data.
  logic [SW-1:0] fe_q_r, lnk_q_r;
  logic          fe_qv_r, vo_qv_r;
  logic [VW-1:0] tgt_q_r, vo_q_r;
  logic [VW-1:0] sv_q_r, sp_q_r, sch_q_r, sl_q_r, so_q_r;
  logic [SW-1:0] sc_q_r;
  logic          sf_q_r;

  // Memories.
  logic [SW-1:0] fe_m  [MAX_VERTICES+1];
  logic [VW-1:0] vo_m  [MAX_VERTICES+1];
  logic [VW-1:0] tgt_m [2*MAX_EDGES+1];
  logic [SW-1:0] lnk_m [2*MAX_EDGES+1];
  logic [VW-1:0] sv_m [MAX_VERTICES], sp_m [MAX_VERTICES], sch_m [MAX_VERTICES];
  logic [VW-1:0] sl_m [MAX_VERTICES], so_m [MAX_VERTICES];
  logic [SW-1:0] sc_m [MAX_VERTICES];
  logic          sf_m [MAX_VERTICES];

  // Derived values.
  logic [SW-1:0] s1, s2, cursor;
  logic [VW-1:0] a_in, b_in, new_ord;
  logic          out_free, op_push;
  assign s1      = SW'({et_r, 1'b1});
  assign s2      = s1 + SW'(1);
  assign cursor  = fe_qv_r ? fe_q_r : '0;
  assign a_in    = VW'(in_end_a);
  assign b_in    = VW'(in_end_b);
  assign new_ord = cnt_r + VW'(1);
  assign out_free = !out_valid || !out_stall;
  assign op_push  = (cmd.op == apf_pkg::OP_CHILD) && (d_r < VW'(MAX_VERTICES));

  // Status toward the controller.
  always_comb begin
    stat.in_take = in_valid && !in_stall;
    stat.in_run  = (in_cmd == apf_pkg::CmdRun);
    stat.add_ok  = (in_end_a != '0) && (in_end_b != '0) && (in_end_a <= n7) &&
                   (in_end_b <= n7) && (et_r < EW'(MAX_EDGES));
    stat.scan_done     = (r_r > {1'b0, n_v});
    stat.root_visited  = vo_vld_r[r_r[VW-1:0]];
    stat.cursor_zero   = (tc_r == '0);
    stat.deep          = (d_r > VW'(1));
    stat.edge_skip     = (tgt_q_r == tp_r) || (tgt_q_r == '0) || (tgt_q_r > n_v);
    stat.tgt_unvisited = !vo_qv_r;
    stat.can_push      = (d_r < VW'(MAX_VERTICES));
    stat.count_done    = (i_r > {1'b0, n_v});
    stat.emit_fin      = out_free &&
                         ((cc_r == '0) || (cut_r[i_r[VW-1:0]] && (em_r + VW'(1) == cc_r)));
  end
  assign in_stall = busy;

  // List head store.
  logic          fe_we;
  logic [VW-1:0] fe_wa, fe_ra;
  logic [SW-1:0] fe_wd;
  always_comb begin
    fe_we = 1'b0;
    fe_wa = a_r;
    fe_wd = s1;
    fe_ra = tgt_q_r;
    case (cmd.op)
      apf_pkg::OP_LOAD: fe_ra = a_in;
      apf_pkg::OP_WR_A: fe_we = 1'b1;
      apf_pkg::OP_RD_B: fe_ra = b_r;
      apf_pkg::OP_WR_B: begin
        fe_we = 1'b1;
        fe_wa = b_r;
        fe_wd = s2;
      end
      apf_pkg::OP_ROOT: fe_ra = r_r[VW-1:0];
      default: fe_ra = tgt_q_r;
    endcase
  end
  always_ff @(posedge clk) begin
    if (fe_we) begin
      fe_m[fe_wa] <= fe_wd;
    end
    fe_q_r  <= fe_m[fe_ra];
    fe_qv_r <= fe_vld_r[fe_ra];
  end

  // Edge slot store.
  logic          ed_we;
  logic [SW-1:0] ed_wa, ed_wl;
  logic [VW-1:0] ed_wt;
  always_comb begin
    ed_we = (cmd.op == apf_pkg::OP_WR_A) || (cmd.op == apf_pkg::OP_WR_B);
    ed_wa = (cmd.op == apf_pkg::OP_WR_B) ? s2 : s1;
    ed_wt = (cmd.op == apf_pkg::OP_WR_B) ? a_r : b_r;
    ed_wl = cursor;
  end
  always_ff @(posedge clk) begin
    if (ed_we) begin
      tgt_m[ed_wa] <= ed_wt;
      lnk_m[ed_wa] <= ed_wl;
    end
    if (cmd.op == apf_pkg::OP_RD_EDGE) begin
      tgt_q_r <= tgt_m[tc_r];
      lnk_q_r <= lnk_m[tc_r];
    end
  end

  // Visit order store.
  logic          vo_we;
  logic [VW-1:0] vo_wa;
  assign vo_we = (cmd.op == apf_pkg::OP_ROOT) || op_push;
  assign vo_wa = (cmd.op == apf_pkg::OP_ROOT) ? r_r[VW-1:0] : tgt_q_r;
  always_ff @(posedge clk) begin
    if (vo_we) begin
      vo_m[vo_wa] <= new_ord;
    end
    if (cmd.op == apf_pkg::OP_TEST) begin
      vo_q_r  <= vo_m[tgt_q_r];
      vo_qv_r <= vo_vld_r[tgt_q_r];
    end
  end

  // Walk stack below the top entry.
  logic [KW-1:0] st_wa, st_ra;
  assign st_wa = KW'(d_r - VW'(1));
  assign st_ra = KW'(d_r - VW'(2));
  always_ff @(posedge clk) begin
    if (op_push) begin
      sv_m[st_wa]  <= tv_r;
      sp_m[st_wa]  <= tp_r;
      sc_m[st_wa]  <= tc_r;
      sch_m[st_wa] <= tch_r + VW'(1);
      sf_m[st_wa]  <= tf_r;
      sl_m[st_wa]  <= tl_r;
      so_m[st_wa]  <= to_r;
    end
    if (cmd.op == apf_pkg::OP_POP) begin
      sv_q_r  <= sv_m[st_ra];
      sp_q_r  <= sp_m[st_ra];
      sc_q_r  <= sc_m[st_ra];
      sch_q_r <= sch_m[st_ra];
      sf_q_r  <= sf_m[st_ra];
      sl_q_r  <= sl_m[st_ra];
      so_q_r  <= so_m[st_ra];
    end
  end

  // Top of stack and payload capture; no reset needed.
  always_ff @(posedge clk) begin
    case (cmd.op)
      apf_pkg::OP_LOAD: begin
        a_r <= a_in;
        b_r <= b_in;
      end
      apf_pkg::OP_ROOT: begin
        tv_r  <= r_r[VW-1:0];
        tp_r  <= '0;
        tch_r <= '0;
        tf_r  <= 1'b0;
        tl_r  <= new_ord;
        to_r  <= new_ord;
      end
      apf_pkg::OP_SET_CUR:   tc_r <= cursor;
      apf_pkg::OP_SKIP_EDGE: tc_r <= lnk_q_r;
      apf_pkg::OP_TEST:      tc_r <= lnk_q_r;
      apf_pkg::OP_CHILD: begin
        if (op_push) begin
          tv_r  <= tgt_q_r;
          tp_r  <= tv_r;
          tch_r <= '0;
          tf_r  <= 1'b0;
          tl_r  <= new_ord;
          to_r  <= new_ord;
        end else begin
          tch_r <= tch_r + VW'(1);
        end
      end
      apf_pkg::OP_BACK: begin
        if (vo_q_r < tl_r) begin
          tl_r <= vo_q_r;
        end
      end
      apf_pkg::OP_MERGE: begin
        tv_r  <= sv_q_r;
        tp_r  <= sp_q_r;
        tc_r  <= sc_q_r;
        tch_r <= sch_q_r;
        tf_r  <= sf_q_r || (tl_r >= so_q_r);
        tl_r  <= (tl_r < sl_q_r) ? tl_r : sl_q_r;
        to_r  <= so_q_r;
      end
      default: begin
        tc_r <= tc_r;
      end
    endcase
  end

  // Cut decision for the vertex that leaves the stack.
  logic pop_cut;
  assign pop_cut = (tp_r == '0) ? (tch_r > VW'(1)) : tf_r;

  // Control state of the walk, count and clear.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      et_r     <= '0;
      drop_r   <= 1'b0;
      ovf_r    <= 1'b0;
      r_r      <= '0;
      i_r      <= '0;
      cnt_r    <= '0;
      cc_r     <= '0;
      em_r     <= '0;
      d_r      <= '0;
      vo_vld_r <= '0;
      fe_vld_r <= '0;
      cut_r    <= '0;
    end else begin
      case (cmd.op)
        apf_pkg::OP_DROP: drop_r <= 1'b1;
        apf_pkg::OP_WR_A: fe_vld_r[a_r] <= 1'b1;
        apf_pkg::OP_WR_B: begin
          fe_vld_r[b_r] <= 1'b1;
          et_r          <= et_r + EW'(1);
        end
        apf_pkg::OP_RUN: begin
          r_r   <= (VW+1)'(1);
          ovf_r <= drop_r;
        end
        apf_pkg::OP_SCAN_SKIP: r_r <= r_r + (VW+1)'(1);
        apf_pkg::OP_ROOT: begin
          cnt_r                 <= new_ord;
          vo_vld_r[r_r[VW-1:0]] <= 1'b1;
          d_r                   <= VW'(1);
        end
        apf_pkg::OP_CHILD: begin
          if (op_push) begin
            cnt_r             <= new_ord;
            vo_vld_r[tgt_q_r] <= 1'b1;
            d_r               <= d_r + VW'(1);
          end
        end
        apf_pkg::OP_POP: begin
          if (pop_cut) begin
            cut_r[tv_r] <= 1'b1;
          end
        end
        apf_pkg::OP_POP_DONE: begin
          if (pop_cut) begin
            cut_r[tv_r] <= 1'b1;
          end
          d_r <= '0;
          r_r <= r_r + (VW+1)'(1);
        end
        apf_pkg::OP_MERGE: d_r <= d_r - VW'(1);
        apf_pkg::OP_COUNT_START: begin
          i_r  <= (VW+1)'(1);
          cc_r <= '0;
        end
        apf_pkg::OP_COUNT: begin
          i_r  <= i_r + (VW+1)'(1);
          cc_r <= cc_r + VW'(cut_r[i_r[VW-1:0]]);
        end
        apf_pkg::OP_EMIT_START: begin
          i_r  <= (VW+1)'(1);
          em_r <= '0;
        end
        apf_pkg::OP_EMIT: begin
          if (cc_r != '0 && (!cut_r[i_r[VW-1:0]] || out_free)) begin
            i_r <= i_r + (VW+1)'(1);
            if (cut_r[i_r[VW-1:0]]) begin
              em_r <= em_r + VW'(1);
            end
          end
        end
        apf_pkg::OP_CLEAR: begin
          et_r     <= '0;
          drop_r   <= 1'b0;
          cnt_r    <= '0;
          d_r      <= '0;
          vo_vld_r <= '0;
          fe_vld_r <= '0;
          cut_r    <= '0;
        end
        default: begin
          d_r <= d_r;
        end
      endcase
    end
  end

  // Output register: a new transaction loads when the slot is free.
  logic emit_now;
  assign emit_now = (cmd.op == apf_pkg::OP_EMIT) && out_free &&
                    ((cc_r == '0) || cut_r[i_r[VW-1:0]]);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (emit_now) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (emit_now) begin
      out_cut_vertex <= (cc_r == '0) ? '0 : FW'(i_r);
      out_found      <= (cc_r != '0);
      out_cut_count  <= FW'(cc_r);
      out_overflow   <= ovf_r;
      out_last       <= stat.emit_fin;
    end
  end

  // Checks on the walk and the stores.
  `AP_NEVER(a_depth_max, clk, rst_n, d_r > VW'(MAX_VERTICES), "stack depth beyond capacity")
  `AP_NEVER(a_edges_max, clk, rst_n, et_r > EW'(MAX_EDGES), "edge total beyond capacity")
  `AP_ASSERT(a_clear, clk, rst_n, cmd.op == apf_pkg::OP_CLEAR |=> d_r == '0 && cut_r == '0, "stores not cleared")
  `AP_ASSERT(a_emit_busy, clk, rst_n, emit_now |-> busy, "result emitted while idle")

endmodule
`default_nettype wire

// ===== dv/articulation_point_finder_test.sv =====
// Self-checking testbench for the articulation point finder.
`timescale 1ns / 100ps
`default_nettype none
module articulation_point_finder_test;

  localparam int FieldW     = apf_pkg::FieldW;
  localparam int NumVert    = 64;
  localparam int NumEdges   = 256;
  localparam int NumSlots   = 2 * NumEdges + 1;
  localparam int IdleLimit  = 200000;
  localparam int DirectedN  = 22;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [FieldW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = apf_pkg::CmdAdd;
  logic [FieldW-1:0] in_end_a = '0;
  logic [FieldW-1:0] in_end_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [FieldW-1:0] out_cut_vertex;
  logic out_found;
  logic [FieldW-1:0] out_cut_count;
  logic out_overflow;
  logic out_last;

  typedef struct packed {
    logic [FieldW-1:0] vertex;
    logic              found;
    logic [FieldW-1:0] count;
    logic              ovf;
    logic              last;
  } cut_report_t;

  typedef struct {
    logic              cmd;
    logic [FieldW-1:0] a;
    logic [FieldW-1:0] b;
    bit                typed;
    cut_report_t       report;
  } stim_row_t;

  articulation_point_finder dut (.*);

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Graph model kept by the testbench.
  int unsigned gr_vcount;
  int unsigned gr_order [NumVert+1];
  int unsigned gr_low [NumVert+1];
  int unsigned gr_head [NumVert+1];
  int unsigned gr_tgt [NumSlots];
  int unsigned gr_next [NumSlots];
  int unsigned st_v [NumVert+1];
  int unsigned st_par [NumVert+1];
  int unsigned st_cur [NumVert+1];
  int unsigned st_kids [NumVert+1];
  bit          st_cut [NumVert+1];
  bit          gr_cut [NumVert+1];
  int unsigned gr_sp, gr_clock, gr_edges;
  bit          gr_dropped;

  cut_report_t cut_reports_due [$];
  int errors = 0;
  int items_taken = 0;
  int reports_seen = 0;
  int runs_sent = 0;
  bit hold_off = 1'b0;

  function automatic void clear_graph();
    for (int i = 0; i <= NumVert; i++) begin
      gr_order[i] = 0;
      gr_head[i] = 0;
      gr_cut[i] = 0;
    end
    gr_sp = 0;
    gr_clock = 0;
    gr_edges = 0;
    gr_dropped = 0;
  endfunction

  // Appends one expected cut report at the tail of the queue.
  function automatic void queue_report(cut_report_t r);
    cut_reports_due.insert(cut_reports_due.size(), r);
  endfunction

  function automatic void visit(int unsigned v, int unsigned par);
    if (gr_sp >= NumVert || v == 0 || v > NumVert) return;
    gr_clock++;
    gr_order[v] = gr_clock;
    gr_low[v] = gr_clock;
    st_v[gr_sp] = v;
    st_par[gr_sp] = par;
    st_cur[gr_sp] = gr_head[v];
    st_kids[gr_sp] = 0;
    st_cut[gr_sp] = 0;
    gr_sp++;
  endfunction

  function automatic void walk_graph(int unsigned root, int unsigned n);
    int unsigned t, u, e, v, p;
    visit(root, 0);
    while (gr_sp > 0) begin
      t = gr_sp - 1;
      u = st_v[t];
      e = st_cur[t];
      if (e != 0 && e < NumSlots) begin
        v = gr_tgt[e];
        st_cur[t] = gr_next[e];
        if (v == st_par[t] || v == 0 || v > n) continue;
        if (gr_order[v] == 0) begin
          st_kids[t]++;
          visit(v, u);
        end else if (gr_order[v] < gr_low[u]) begin
          gr_low[u] = gr_order[v];
        end
        continue;
      end
      gr_sp = t;
      if (st_par[t] == 0) begin
        if (st_kids[t] > 1) gr_cut[u] = 1;
      end else if (st_cut[t]) begin
        gr_cut[u] = 1;
      end
      if (t > 0) begin
        p = st_v[t-1];
        if (gr_low[u] >= gr_order[p]) st_cut[t-1] = 1;
        if (gr_low[u] < gr_low[p]) gr_low[p] = gr_low[u];
      end
    end
  endfunction

  // Applies one transaction to the model and queues the cut reports it causes.
  function automatic void predict_cuts(logic cmd, int unsigned a, int unsigned b);
    int unsigned n, cnt, k, s;
    cut_report_t r;
    n = (gr_vcount > NumVert) ? NumVert : gr_vcount;
    if (cmd == apf_pkg::CmdAdd) begin
      if (a == 0 || b == 0 || a > n || b > n || gr_edges >= NumEdges) begin
        gr_dropped = 1;
        return;
      end
      s = 2 * gr_edges + 1;
      gr_tgt[s] = b; gr_next[s] = gr_head[a]; gr_head[a] = s;
      s = s + 1;
      gr_tgt[s] = a; gr_next[s] = gr_head[b]; gr_head[b] = s;
      gr_edges++;
      return;
    end
    for (int v = 1; v <= n; v++)
      if (gr_order[v] == 0) walk_graph(v, n);
    cnt = 0;
    for (int v = 1; v <= n; v++) cnt += gr_cut[v];
    if (cnt == 0) begin
      r = '{vertex: '0, found: 1'b0, count: '0, ovf: gr_dropped, last: 1'b1};
      queue_report(r);
    end else begin
      k = 0;
      for (int v = 1; v <= n; v++) begin
        if (!gr_cut[v]) continue;
        k++;
        r = '{vertex: v[FieldW-1:0], found: 1'b1, count: cnt[FieldW-1:0],
              ovf: gr_dropped, last: (k == cnt)};
        queue_report(r);
      end
    end
    clear_graph();
  endfunction

  // Result checker.
  always @(posedge clk) begin
    cut_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      reports_seen++;
      if (cut_reports_due.size() == 0) begin
        $error("unexpected result: cut_vertex %0d", out_cut_vertex);
        errors++;
      end else begin
        want = cut_reports_due.pop_front();
        if (out_cut_vertex !== want.vertex) begin
          $error("cut_vertex expected %0d actual %0d", want.vertex, out_cut_vertex);
          errors++;
        end
        if (out_found !== want.found) begin
          $error("found expected %0d actual %0d", want.found, out_found);
          errors++;
        end
        if (out_cut_count !== want.count) begin
          $error("cut_count expected %0d actual %0d", want.count, out_cut_count);
          errors++;
        end
        if (out_overflow !== want.ovf) begin
          $error("overflow expected %0d actual %0d", want.ovf, out_overflow);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("last expected %0d actual %0d", want.last, out_last);
          errors++;
        end
      end
    end
  end

  // Receiver: random stall per result, or a long hold-off on request.
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else if (out_valid && !out_stall) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap - 1) @(posedge clk);
        end
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no accepted transaction.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("articulation_point_finder test failed");
        $finish;
      end
    end
  end

  // Offers one transaction; valid stays up afterwards so that a gap of zero
  // gives back-to-back transactions. Callers that go idle lower it.
  task automatic send_item(logic cmd, logic [FieldW-1:0] a, logic [FieldW-1:0] b,
                           bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_end_a <= a;
    in_end_b <= b;
    do @(posedge clk); while (in_stall);
    items_taken++;
    if (cmd == apf_pkg::CmdRun) runs_sent++;
    predict_cuts(cmd, a, b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (cut_reports_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_vcount(logic [FieldW-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gr_vcount = value;
  endtask

  // Random graph: a path through the first k vertices, chords and noise.
  task automatic random_graph(int unsigned n);
    int unsigned k, m;
    k = $urandom_range(2, (n < 12) ? n : 12);
    for (int v = 1; v < k; v++)
      send_item(apf_pkg::CmdAdd, FieldW'(v), FieldW'(v + 1), 1'b1);
    m = $urandom_range(0, 4);
    for (int i = 0; i < m; i++) begin
      if ($urandom_range(0, 4) == 0)
        send_item(apf_pkg::CmdAdd, FieldW'($urandom_range(0, 127)),
                  FieldW'($urandom_range(0, 127)), 1'b1);
      else
        send_item(apf_pkg::CmdAdd, FieldW'($urandom_range(1, k)),
                  FieldW'($urandom_range(1, k)), 1'b1);
    end
    send_item(apf_pkg::CmdRun, FieldW'($urandom_range(0, 127)),
              FieldW'($urandom_range(0, 127)), 1'b1);
  endtask

  initial begin
    stim_row_t rows [DirectedN];
    int n;
    gr_vcount = apf_pkg::VcReset;
    clear_graph();
    // Directed rows: after reset, extremes, star, bad endpoints, loops.
    rows[0]  = '{apf_pkg::CmdRun, 7'd0, 7'd0, 1, '{7'd0, 1'b0, 7'd0, 1'b0, 1'b1}};
    rows[1]  = '{apf_pkg::CmdAdd, 7'd0, 7'd5, 0, '0};
    rows[2]  = '{apf_pkg::CmdRun, 7'd127, 7'd127, 1, '{7'd0, 1'b0, 7'd0, 1'b1, 1'b1}};
    rows[3]  = '{apf_pkg::CmdAdd, 7'd1, 7'd64, 0, '0};
    rows[4]  = '{apf_pkg::CmdAdd, 7'd64, 7'd2, 0, '0};
    rows[5]  = '{apf_pkg::CmdAdd, 7'd64, 7'd3, 0, '0};
    rows[6]  = '{apf_pkg::CmdAdd, 7'd65, 7'd3, 0, '0};
    rows[7]  = '{apf_pkg::CmdRun, 7'd0, 7'd0, 1, '{7'd64, 1'b1, 7'd1, 1'b1, 1'b1}};
    rows[8]  = '{apf_pkg::CmdAdd, 7'd1, 7'd2, 0, '0};
    rows[9]  = '{apf_pkg::CmdAdd, 7'd2, 7'd3, 0, '0};
    rows[10] = '{apf_pkg::CmdAdd, 7'd3, 7'd4, 0, '0};
    rows[11] = '{apf_pkg::CmdAdd, 7'd3, 7'd3, 0, '0};
    rows[12] = '{apf_pkg::CmdAdd, 7'd2, 7'd3, 0, '0};
    rows[13] = '{apf_pkg::CmdRun, 7'd85, 7'd42, 0, '0};
    rows[14] = '{apf_pkg::CmdAdd, 7'd1, 7'd2, 0, '0};
    rows[15] = '{apf_pkg::CmdAdd, 7'd2, 7'd3, 0, '0};
    rows[16] = '{apf_pkg::CmdAdd, 7'd3, 7'd1, 0, '0};
    rows[17] = '{apf_pkg::CmdRun, 7'd42, 7'd85, 1, '{7'd0, 1'b0, 7'd0, 1'b0, 1'b1}};
    rows[18] = '{apf_pkg::CmdAdd, 7'd4, 7'd5, 0, '0};
    rows[19] = '{apf_pkg::CmdAdd, 7'd5, 7'd6, 0, '0};
    rows[20] = '{apf_pkg::CmdAdd, 7'd6, 7'd7, 0, '0};
    rows[21] = '{apf_pkg::CmdRun, 7'd0, 7'd0, 0, '0};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the table; typed rows also get their result checked here.
    for (int i = 0; i < DirectedN; i++) begin
      send_item(rows[i].cmd, rows[i].a, rows[i].b, 1'b1);
      if (rows[i].typed && cut_reports_due.size() != 0 &&
          cut_reports_due[$] !== rows[i].report) begin
        $error("table row %0d: cut_report expected %h actual %h", i,
               rows[i].report, cut_reports_due[$]);
        errors++;
      end
    end

    // Vertex count extremes, zero and out of range.
    write_vcount(7'd1);
    send_item(apf_pkg::CmdAdd, 7'd1, 7'd1, 1'b1);
    send_item(apf_pkg::CmdAdd, 7'd1, 7'd2, 1'b1);
    send_item(apf_pkg::CmdRun, 7'd0, 7'd0, 1'b1);
    write_vcount(7'd0);
    send_item(apf_pkg::CmdRun, 7'd0, 7'd0, 1'b1);
    write_vcount(7'd127);
    send_item(apf_pkg::CmdAdd, 7'd63, 7'd64, 1'b1);
    send_item(apf_pkg::CmdAdd, 7'd64, 7'd62, 1'b1);
    // Lowering the count after loading hides the far edges.
    write_vcount(7'd63);
    send_item(apf_pkg::CmdRun, 7'd0, 7'd0, 1'b1);

    // Random phases at several vertex counts.
    for (int phase = 0; phase < 4; phase++) begin
      n = (phase == 0) ? 4 : (phase == 1) ? 64 : $urandom_range(2, 64);
      write_vcount(FieldW'(n));
      for (int g = 0; g < 3; g++) begin
        if (phase == 1 && g == 0) hold_off = 1'b1;
        random_graph(n);
      end
      // In phase 2 the sender rests until every result is back.
      if (phase == 2) drain();
    end

    drain();
    $display("Covered %0d input transactions, %0d graph runs, %0d cut reports checked.",
             items_taken, runs_sent, reports_seen);
    if (errors == 0) begin
      $display("articulation_point_finder test passed");
    end else begin
      $display("articulation_point_finder test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
